// ===== rtl/bzs_pkg.sv =====
// Shared types, widths and helpers for the cubic Bezier parameter solver.
// No dependencies; every other file in rtl/ uses it by scoped name.
package bzs_pkg;

   localparam int POINT_W = 32;
   localparam int POS_W   = 17;
   localparam int VAL_W   = 51;            // saturated Q34.16 value, +-(2^50 - 1)
   localparam int MAG_W   = VAL_W - 1;
   localparam int T_W     = 33;            // signed t, holds +-2^(FRAC_BITS+1) up to 30 bits

   localparam int BISECT_STEPS_DEF = 4;
   localparam int NEWTON_STEPS_DEF = 10;
   localparam int FRAC_BITS_DEF    = 16;

   localparam logic [MAG_W-1:0]        VAL_MAX   = {MAG_W{1'b1}};
   localparam logic signed [VAL_W-1:0] VAL_POS   = {1'b0, VAL_MAX};
   localparam logic signed [VAL_W-1:0] VAL_NEG   = -VAL_POS;
   localparam logic signed [VAL_W+1:0] VAL_POS_X = {3'b000, VAL_MAX};
   localparam logic signed [VAL_W+1:0] VAL_NEG_X = -VAL_POS_X;
   localparam logic [POS_W-1:0]        POS_ONE   = {1'b1, 16'd0};

   typedef struct packed {
      logic signed [POINT_W-1:0] point0;
      logic signed [POINT_W-1:0] point1;
      logic signed [POINT_W-1:0] point2;
      logic signed [POINT_W-1:0] point3;
      logic [POS_W-1:0]          position;
   } req_word_type;

   typedef struct packed {
      logic [POS_W-1:0] param_t;
      logic             out_of_range;
   } rsp_word_type;

   // per-item context carried down the solver pipeline
   typedef struct packed {
      logic                    done;
      logic                    done_one;
      logic signed [VAL_W-1:0] a;
      logic signed [VAL_W-1:0] a3;
      logic signed [VAL_W-1:0] b;
      logic signed [VAL_W-1:0] b2;
      logic signed [VAL_W-1:0] c;
      logic signed [VAL_W-1:0] nxv;
      logic signed [T_W-1:0]   t;
      logic signed [T_W-1:0]   lo;
      logic signed [T_W-1:0]   hi;
   } ctx_type;

   function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [VAL_W+1:0] x);
      logic signed [VAL_W-1:0] r;
      if (x > VAL_POS_X) begin
         r = VAL_POS;
      end else if (x < VAL_NEG_X) begin
         r = VAL_NEG;
      end else begin
         r = x[VAL_W-1:0];
      end
      return r;
   endfunction

   function automatic logic [MAG_W-1:0] mag_of(input logic signed [VAL_W-1:0] x);
      logic signed [VAL_W-1:0] n;
      n = -x;
      return x[VAL_W-1] ? n[MAG_W-1:0] : x[MAG_W-1:0];
   endfunction

endpackage

// ===== rtl/bzs_mac.sv =====
// Pipelined multiply-shift-add: y = sat(sat(x*t >> FRAC_BITS) + add), four stages.
// Depends on bzs_pkg.
module bzs_mac #(
   parameter int FRAC_BITS = bzs_pkg::FRAC_BITS_DEF,
   parameter int SIDE_W    = 1
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              valid_i,
   input  logic signed [bzs_pkg::VAL_W-1:0]  x_i,
   input  logic signed [bzs_pkg::T_W-1:0]    t_i,
   input  logic signed [bzs_pkg::VAL_W-1:0]  add_i,
   input  logic [SIDE_W-1:0]                 side_i,
   output logic                              valid_o,
   output logic signed [bzs_pkg::VAL_W-1:0]  y_o,
   output logic [SIDE_W-1:0]                 side_o
);

   localparam int VW     = bzs_pkg::VAL_W;
   localparam int MW     = bzs_pkg::MAG_W;
   localparam int SPL    = MW / 2;
   localparam int TMW    = bzs_pkg::T_W - 1;
   localparam int PP_W   = (MW - SPL) + TMW;
   localparam int PROD_W = MW + TMW;

   logic [3:0]              v_ff;
   logic [SIDE_W-1:0]       side_ff [4];
   logic signed [VW-1:0]    add_ff  [3];
   logic [2:0]              neg_ff;
   logic [MW-1:0]           xm_ff;
   logic [TMW-1:0]          tm_ff;
   logic [PP_W-1:0]         pl_ff, ph_ff;
   logic [MW-1:0]           mag_ff;
   logic signed [VW-1:0]    y_ff;

   logic signed [bzs_pkg::T_W-1:0] tneg;
   logic [TMW-1:0]                 tm_in;
   logic [PROD_W-1:0]              prod, shifted;
   logic [MW-1:0]                  mag_in;
   logic signed [VW+1:0]           sum;

   always_comb begin
      tneg    = -t_i;
      tm_in   = t_i[bzs_pkg::T_W-1] ? tneg[TMW-1:0] : t_i[TMW-1:0];
      prod    = (PROD_W'(ph_ff) << SPL) + PROD_W'(pl_ff);
      shifted = prod >> FRAC_BITS;
      mag_in  = (shifted > PROD_W'(bzs_pkg::VAL_MAX)) ? bzs_pkg::VAL_MAX : shifted[MW-1:0];
      if (neg_ff[2]) begin
         sum = {{2{add_ff[2][VW-1]}}, add_ff[2]} - $signed({3'b000, mag_ff});
      end else begin
         sum = {{2{add_ff[2][VW-1]}}, add_ff[2]} + $signed({3'b000, mag_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[2:0], valid_i};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // stage 1: magnitudes
         xm_ff      <= bzs_pkg::mag_of(x_i);
         tm_ff      <= tm_in;
         neg_ff[0]  <= x_i[VW-1] ^ t_i[bzs_pkg::T_W-1];
         add_ff[0]  <= add_i;
         side_ff[0] <= side_i;
         // stage 2: two partial products
         pl_ff      <= PP_W'(xm_ff[SPL-1:0]) * PP_W'(tm_ff);
         ph_ff      <= PP_W'(xm_ff[MW-1:SPL]) * PP_W'(tm_ff);
         neg_ff[1]  <= neg_ff[0];
         add_ff[1]  <= add_ff[0];
         side_ff[1] <= side_ff[0];
         // stage 3: recombine, shift, saturate
         mag_ff     <= mag_in;
         neg_ff[2]  <= neg_ff[1];
         add_ff[2]  <= add_ff[1];
         side_ff[2] <= side_ff[1];
         // stage 4: signed add, saturate
         y_ff       <= bzs_pkg::sat_val(sum);
         side_ff[3] <= side_ff[2];
      end
   end

   assign valid_o = v_ff[3];
   assign y_o     = y_ff;
   assign side_o  = side_ff[3];

endmodule

// ===== rtl/bzs_div.sv =====
// Pipelined restoring divider: |num|/|den| in Q(FRAC_BITS), capped at 4.0, one bit a stage.
// Depends on bzs_pkg.
module bzs_div #(
   parameter int FRAC_BITS = bzs_pkg::FRAC_BITS_DEF,
   parameter int SIDE_W    = 1
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              valid_i,
   input  logic signed [bzs_pkg::VAL_W-1:0]  num_i,
   input  logic signed [bzs_pkg::VAL_W-1:0]  den_i,
   input  logic [SIDE_W-1:0]                 side_i,
   output logic                              valid_o,
   output logic                              neg_o,
   output logic [FRAC_BITS+2:0]              mag_o,
   output logic [SIDE_W-1:0]                 side_o
);

   localparam int MW    = bzs_pkg::MAG_W;
   localparam int RW    = MW + 2;
   localparam int NSTEP = FRAC_BITS + 2;
   localparam int QW    = NSTEP;

   typedef struct packed {
      logic          cap;
      logic          neg;
      logic [RW-1:0] r;
      logic [MW-1:0] ud;
      logic [QW-1:0] q;
   } dstage_type;

   logic              v0_ff;
   logic [MW-1:0]     un_ff, ud_ff;
   logic              neg_ff;
   logic [SIDE_W-1:0] side0_ff;

   dstage_type        st_ff   [NSTEP+1];
   logic [SIDE_W-1:0] side_ff [NSTEP+1];
   logic              v_ff    [NSTEP+1];
   dstage_type        st0_in;

   always_comb begin
      st0_in.cap = {2'b00, un_ff} >= {ud_ff, 2'b00};
      st0_in.neg = neg_ff;
      st0_in.r   = RW'(un_ff);
      st0_in.ud  = ud_ff;
      st0_in.q   = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff   <= 1'b0;
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v0_ff   <= valid_i;
         v_ff[0] <= v0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         un_ff      <= bzs_pkg::mag_of(num_i);
         ud_ff      <= bzs_pkg::mag_of(den_i);
         neg_ff     <= num_i[bzs_pkg::VAL_W-1] ^ den_i[bzs_pkg::VAL_W-1];
         side0_ff   <= side_i;
         st_ff[0]   <= st0_in;
         side_ff[0] <= side0_ff;
      end
   end

   for (genvar i = 0; i < NSTEP; i++) begin : g_step
      logic [RW-1:0] cmp, dv;
      logic          ge;
      dstage_type    st_in;

      // two integer quotient bits first, then the fraction bits
      if (i < 2) begin : g_int
         assign cmp = st_ff[i].r;
         assign dv  = RW'(st_ff[i].ud) << (1 - i);
      end else begin : g_frac
         assign cmp = st_ff[i].r << 1;
         assign dv  = RW'(st_ff[i].ud);
      end

      always_comb begin
         ge       = cmp >= dv;
         st_in    = st_ff[i];
         st_in.r  = ge ? cmp - dv : cmp;
         st_in.q  = {st_ff[i].q[QW-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i+1] <= 1'b0;
         end else if (en) begin
            v_ff[i+1] <= v_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            st_ff[i+1]   <= st_in;
            side_ff[i+1] <= side_ff[i];
         end
      end
   end

   assign valid_o = v_ff[NSTEP];
   assign neg_o   = st_ff[NSTEP].neg;
   assign mag_o   = st_ff[NSTEP].cap ? {1'b1, {(FRAC_BITS+2){1'b0}}}
                                     : {1'b0, st_ff[NSTEP].q};
   assign side_o  = side_ff[NSTEP];

endmodule

// ===== rtl/bezier_param_from_x_solver_top.sv =====
// Cubic Bezier parameter solver, top level: setup stages, bisection and Newton chains.
// Depends on bzs_pkg, bzs_mac and bzs_div.
//
// Given the four control coordinates of one curve axis (signed Q16.16) and a
// normalized position w (Q1.16, 65536 = 1.0), returns the parameter t (Q1.16)
// where the curve reaches p0 + w*(p3-p0). Fully pipelined: one word in and one
// word out per cycle, in order, while the rsp side does not stall. Each Newton
// step chains five 4-stage multiply-add units and a divider that makes one
// quotient bit per stage; each bisection step chains three multiply-add units.
// Flat start (w = 0 and p0 = p1) gives 0; flat end (w = 1.0 and p2 = p3) gives
// 1.0. A zero derivative leaves t alone for that step. A final t outside [0,1]
// returns 0 with out_of_range set. A stalled rsp side holds the pipe only once a
// finished word reaches the last stage; until then req keeps being taken.
module bezier_param_from_x_solver_top #(
   parameter int BISECT_STEPS = bzs_pkg::BISECT_STEPS_DEF,
   parameter int NEWTON_STEPS = bzs_pkg::NEWTON_STEPS_DEF,
   parameter int FRAC_BITS    = bzs_pkg::FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  bzs_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output bzs_pkg::rsp_word_type rsp_data
);

   localparam int VW     = bzs_pkg::VAL_W;
   localparam int TW     = bzs_pkg::T_W;
   localparam int PW     = bzs_pkg::POS_W;
   localparam int D_W    = bzs_pkg::POINT_W + 1;
   localparam int XP_W   = PW + D_W;
   localparam int XM_W   = XP_W - 16;
   localparam int UPD_W  = TW + 2;
   localparam int NSTEPS = BISECT_STEPS + NEWTON_STEPS;
   localparam int CTX_W  = $bits(bzs_pkg::ctx_type);

   localparam logic signed [UPD_W-1:0] T_LIM = UPD_W'(64'd1 << (FRAC_BITS + 1));
   localparam logic signed [TW-1:0]    T_ONE = TW'(64'd1 << FRAC_BITS);

   typedef struct packed {
      bzs_pkg::ctx_type        ctx;
      logic signed [VW-1:0]    g;
   } dside_type;

   typedef struct packed {
      bzs_pkg::ctx_type ctx;
      logic             dz;
   } qside_type;

   logic adv;

   // ---------------- setup: coefficients, target, starting t ----------------
   logic [4:0]                 sv_ff;
   bzs_pkg::req_word_type      in_ff;
   logic signed [D_W-1:0]      d10_ff, d21_ff, d30_ff;
   logic [PW-1:0]              w_ff [4];
   logic [3:0]                 flat0_ff, flat1_ff;
   logic signed [VW-1:0]       c_ff [3];
   logic signed [VW-1:0]       b3_ff, b_ff [2], ac_ff, d30x_ff, a_ff;
   logic [D_W-1:0]             d30m_ff;
   logic [1:0]                 d30neg_ff;
   logic [XM_W-1:0]            xvm_ff;
   logic signed [VW-1:0]       nxv_ff;
   logic signed [D_W-1:0]      d30neg_v;
   logic [XP_W-1:0]            xp;
   logic signed [TW-1:0]       t0_in;
   bzs_pkg::ctx_type           ctx0_in;

   // chain of per-step context registers
   bzs_pkg::ctx_type ctx_ff [NSTEPS+1];
   logic             cv_ff  [NSTEPS+1];

   assign adv       = !(cv_ff[NSTEPS] && rsp_valid && rsp_stall);
   assign req_stall = !adv;

   if (FRAC_BITS >= 16) begin : g_t0_up
      assign t0_in = $signed(TW'(w_ff[3])) <<< (FRAC_BITS - 16);
   end else begin : g_t0_dn
      assign t0_in = $signed(TW'(w_ff[3] >> (16 - FRAC_BITS)));
   end

   always_comb begin
      d30neg_v         = -d30_ff;
      xp               = XP_W'(w_ff[1]) * XP_W'(d30m_ff);
      ctx0_in.done     = flat0_ff[3] || flat1_ff[3];
      ctx0_in.done_one = !flat0_ff[3] && flat1_ff[3];
      ctx0_in.a        = a_ff;
      ctx0_in.a3       = a_ff + (a_ff <<< 1);
      ctx0_in.b        = b_ff[1];
      ctx0_in.b2       = b_ff[1] <<< 1;
      ctx0_in.c        = c_ff[2];
      ctx0_in.nxv      = nxv_ff;
      ctx0_in.t        = t0_in;
      ctx0_in.lo       = '0;
      ctx0_in.hi       = T_ONE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff    <= '0;
         cv_ff[0] <= 1'b0;
      end else if (adv) begin
         sv_ff    <= {sv_ff[3:0], req_valid};
         cv_ff[0] <= sv_ff[4];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         in_ff        <= req_data;
         // differences and early-exit tests
         d10_ff       <= D_W'(in_ff.point1) - D_W'(in_ff.point0);
         d21_ff       <= D_W'(in_ff.point2) - D_W'(in_ff.point1);
         d30_ff       <= D_W'(in_ff.point3) - D_W'(in_ff.point0);
         w_ff[0]      <= in_ff.position;
         flat0_ff[0]  <= (in_ff.position == '0) && (in_ff.point0 == in_ff.point1);
         flat1_ff[0]  <= (in_ff.position == bzs_pkg::POS_ONE) &&
                         (in_ff.point2 == in_ff.point3);
         // c = 3(p1-p0), 3(p2-p1), |p3-p0|
         c_ff[0]      <= VW'(d10_ff) + (VW'(d10_ff) <<< 1);
         b3_ff        <= VW'(d21_ff) + (VW'(d21_ff) <<< 1);
         d30m_ff      <= d30_ff[D_W-1] ? d30neg_v : d30_ff;
         d30neg_ff[0] <= d30_ff[D_W-1];
         d30x_ff      <= VW'(d30_ff);
         w_ff[1]      <= w_ff[0];
         flat0_ff[1]  <= flat0_ff[0];
         flat1_ff[1]  <= flat1_ff[0];
         // b, target magnitude, p3-p0-c
         b_ff[0]      <= b3_ff - c_ff[0];
         xvm_ff       <= xp[XP_W-1:16];
         ac_ff        <= d30x_ff - c_ff[0];
         c_ff[1]      <= c_ff[0];
         d30neg_ff[1] <= d30neg_ff[0];
         w_ff[2]      <= w_ff[1];
         flat0_ff[2]  <= flat0_ff[1];
         flat1_ff[2]  <= flat1_ff[1];
         // a, negated target
         a_ff         <= ac_ff - b_ff[0];
         nxv_ff       <= d30neg_ff[1] ? $signed(VW'(xvm_ff)) : -$signed(VW'(xvm_ff));
         b_ff[1]      <= b_ff[0];
         c_ff[2]      <= c_ff[1];
         w_ff[3]      <= w_ff[2];
         flat0_ff[3]  <= flat0_ff[2];
         flat1_ff[3]  <= flat1_ff[2];
         // 3a, 2b and starting t folded into the context
         ctx_ff[0]    <= ctx0_in;
      end
   end

   // ---------------- bisection steps ----------------
   for (genvar k = 0; k < BISECT_STEPS; k++) begin : g_bis
      bzs_pkg::ctx_type     mid_ff, mid_in, s1, s2, s3, upd;
      logic                 mid_v_ff, v1, v2, v3;
      logic signed [VW-1:0] y1, y2, g;

      always_comb begin
         mid_in   = ctx_ff[k];
         mid_in.t = (ctx_ff[k].lo + ctx_ff[k].hi) >>> 1;
         upd      = s3;
         if (g < 0) begin
            upd.lo = s3.t;
         end else begin
            upd.hi = s3.t;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            mid_v_ff   <= 1'b0;
            cv_ff[k+1] <= 1'b0;
         end else if (adv) begin
            mid_v_ff   <= cv_ff[k];
            cv_ff[k+1] <= v3;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            mid_ff      <= mid_in;
            ctx_ff[k+1] <= upd;
         end
      end

      bzs_mac #(.FRAC_BITS(FRAC_BITS), .SIDE_W(CTX_W)) u_f1 (
         .clock(clock), .reset(reset), .en(adv), .valid_i(mid_v_ff),
         .x_i(mid_ff.a), .t_i(mid_ff.t), .add_i(mid_ff.b), .side_i(mid_ff),
         .valid_o(v1), .y_o(y1), .side_o(s1));
      bzs_mac #(.FRAC_BITS(FRAC_BITS), .SIDE_W(CTX_W)) u_f2 (
         .clock(clock), .reset(reset), .en(adv), .valid_i(v1),
         .x_i(y1), .t_i(s1.t), .add_i(s1.c), .side_i(s1),
         .valid_o(v2), .y_o(y2), .side_o(s2));
      bzs_mac #(.FRAC_BITS(FRAC_BITS), .SIDE_W(CTX_W)) u_f3 (
         .clock(clock), .reset(reset), .en(adv), .valid_i(v2),
         .x_i(y2), .t_i(s2.t), .add_i(s2.nxv), .side_i(s2),
         .valid_o(v3), .y_o(g), .side_o(s3));
   end

   // ---------------- Newton steps ----------------
   for (genvar j = 0; j < NEWTON_STEPS; j++) begin : g_newton
      localparam int K = BISECT_STEPS + j;

      bzs_pkg::ctx_type     s1, s2, s3, upd;
      dside_type            ds_in, ds1, ds2;
      qside_type            qs_in, qs;
      logic                 v1, v2, v3, v4, v5, vq, qneg;
      logic signed [VW-1:0] y1, y2, g, yd1, d;
      logic [FRAC_BITS+2:0] qmag;
      logic signed [UPD_W-1:0] t_ext, mag_ext, ts, tsat;

      always_comb begin
         ds_in.ctx = s3;
         ds_in.g   = g;
         qs_in.ctx = ds2.ctx;
         qs_in.dz  = (d == '0);
         t_ext     = UPD_W'(qs.ctx.t);
         mag_ext   = $signed(UPD_W'(qmag));
         ts        = qneg ? t_ext + mag_ext : t_ext - mag_ext;
         if (ts > T_LIM) begin
            tsat = T_LIM;
         end else if (ts < -T_LIM) begin
            tsat = -T_LIM;
         end else begin
            tsat = ts;
         end
         upd = qs.ctx;
         if (!qs.dz) begin
            upd.t = tsat[TW-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            cv_ff[K+1] <= 1'b0;
         end else if (adv) begin
            cv_ff[K+1] <= vq;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            ctx_ff[K+1] <= upd;
         end
      end

      // f(t) - xv
      bzs_mac #(.FRAC_BITS(FRAC_BITS), .SIDE_W(CTX_W)) u_f1 (
         .clock(clock), .reset(reset), .en(adv), .valid_i(cv_ff[K]),
         .x_i(ctx_ff[K].a), .t_i(ctx_ff[K].t), .add_i(ctx_ff[K].b), .side_i(ctx_ff[K]),
         .valid_o(v1), .y_o(y1), .side_o(s1));
      bzs_mac #(.FRAC_BITS(FRAC_BITS), .SIDE_W(CTX_W)) u_f2 (
         .clock(clock), .reset(reset), .en(adv), .valid_i(v1),
         .x_i(y1), .t_i(s1.t), .add_i(s1.c), .side_i(s1),
         .valid_o(v2), .y_o(y2), .side_o(s2));
      bzs_mac #(.FRAC_BITS(FRAC_BITS), .SIDE_W(CTX_W)) u_f3 (
         .clock(clock), .reset(reset), .en(adv), .valid_i(v2),
         .x_i(y2), .t_i(s2.t), .add_i(s2.nxv), .side_i(s2),
         .valid_o(v3), .y_o(g), .side_o(s3));

      // f'(t)
      bzs_mac #(.FRAC_BITS(FRAC_BITS), .SIDE_W($bits(dside_type))) u_d1 (
         .clock(clock), .reset(reset), .en(adv), .valid_i(v3),
         .x_i(s3.a3), .t_i(s3.t), .add_i(s3.b2), .side_i(ds_in),
         .valid_o(v4), .y_o(yd1), .side_o(ds1));
      bzs_mac #(.FRAC_BITS(FRAC_BITS), .SIDE_W($bits(dside_type))) u_d2 (
         .clock(clock), .reset(reset), .en(adv), .valid_i(v4),
         .x_i(yd1), .t_i(ds1.ctx.t), .add_i(ds1.ctx.c), .side_i(ds1),
         .valid_o(v5), .y_o(d), .side_o(ds2));

      // step = (f - xv) / f'
      bzs_div #(.FRAC_BITS(FRAC_BITS), .SIDE_W($bits(qside_type))) u_div (
         .clock(clock), .reset(reset), .en(adv), .valid_i(v5),
         .num_i(ds2.g), .den_i(d), .side_i(qs_in),
         .valid_o(vq), .neg_o(qneg), .mag_o(qmag), .side_o(qs));
   end

   // ---------------- result conversion and output register ----------------
   bzs_pkg::rsp_word_type rsp_ff, rsp_in;
   logic                  rsp_valid_ff;
   logic [TW-1:0]         tu;
   logic                  in_range;

   if (FRAC_BITS >= 16) begin : g_out_dn
      assign tu = ctx_ff[NSTEPS].t >> (FRAC_BITS - 16);
   end else begin : g_out_up
      assign tu = ctx_ff[NSTEPS].t << (16 - FRAC_BITS);
   end

   always_comb begin
      in_range = !ctx_ff[NSTEPS].t[TW-1] && (ctx_ff[NSTEPS].t <= T_ONE);
      if (ctx_ff[NSTEPS].done) begin
         rsp_in.param_t      = ctx_ff[NSTEPS].done_one ? bzs_pkg::POS_ONE : '0;
         rsp_in.out_of_range = 1'b0;
      end else begin
         rsp_in.param_t      = in_range ? tu[PW-1:0] : '0;
         rsp_in.out_of_range = !in_range;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cv_ff[NSTEPS] && adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cv_ff[NSTEPS] && adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for bezier_param_from_x_solver_top: directed and random words,
// a fixed-point predictor in a scoreboard class, random idling on both sides.
// Depends on bzs_pkg and the RTL top level.
module testbench;

   localparam int RUN_LIMIT   = 400000;   // cycles
   localparam int DRAIN_WAIT  = 600;      // beyond the solver latency
   localparam int PHASE_WORDS = 475;

   // Expected-result store plus the solver predictor
   class solver_scoreboard;
      bzs_pkg::rsp_word_type want_q[$];
      int errors = 0;

      static function longint sat_v(longint x);
         longint vmax = 64'h3FFFFFFFFFFFF;
         if (x > vmax) return vmax;
         if (x < -vmax) return -vmax;
         return x;
      endfunction

      static function longint mul_q(longint x, longint y);
         longint vmax = 64'h3FFFFFFFFFFFF;
         logic [127:0] prod;
         logic [63:0] ux, uy;
         longint mag;
         ux = (x < 0) ? -x : x;
         uy = (y < 0) ? -y : y;
         prod = ({64'd0, ux} * {64'd0, uy}) >> 16;
         mag = (prod > 128'(vmax)) ? vmax : longint'(prod[63:0]);
         return ((x < 0) != (y < 0)) ? -mag : mag;
      endfunction

      static function longint div_q(longint num, longint den);
         logic [127:0] un, ud, quo;
         longint mag;
         un = (num < 0) ? -num : num;
         ud = (den < 0) ? -den : den;
         if (un / ud >= 4) mag = 4 * 65536;
         else begin
            quo = (un << 16) / ud;
            mag = longint'(quo[63:0]);
         end
         return ((num < 0) != (den < 0)) ? -mag : mag;
      endfunction

      static function longint curve_at(longint a, longint b, longint c, longint t);
         return mul_q(sat_v(mul_q(sat_v(mul_q(a, t) + b), t) + c), t);
      endfunction

      static function bzs_pkg::rsp_word_type solve_param(bzs_pkg::req_word_type w);
         bzs_pkg::rsp_word_type r;
         longint p0, p1, p2, p3, pos, a, b, c, xv, t, lo, hi, f, d;
         p0 = longint'(w.point0);
         p1 = longint'(w.point1);
         p2 = longint'(w.point2);
         p3 = longint'(w.point3);
         pos = longint'(w.position);
         r = '0;
         if (pos == 0 && p0 == p1) return r;       // flat start
         if (pos == 65536 && p2 == p3) begin       // flat end
            r.param_t = bzs_pkg::POS_ONE;
            return r;
         end
         xv = mul_q(pos, p3 - p0);
         c = 3 * (p1 - p0);
         b = 3 * (p2 - p1) - c;
         a = p3 - p0 - c - b;
         t = pos;
         lo = 0;
         hi = 65536;
         for (int i = 0; i < bzs_pkg::BISECT_STEPS_DEF; i++) begin
            t = (lo + hi) >>> 1;
            f = curve_at(a, b, c, t);
            if (sat_v(f - xv) < 0) lo = t;
            else hi = t;
         end
         for (int i = 0; i < bzs_pkg::NEWTON_STEPS_DEF; i++) begin
            f = curve_at(a, b, c, t);
            d = sat_v(mul_q(sat_v(mul_q(3 * a, t) + 2 * b), t) + c);
            if (d == 0) continue;                  // zero slope keeps t
            t = t - div_q(sat_v(f - xv), d);
            if (t > 131072) t = 131072;
            if (t < -131072) t = -131072;
         end
         if (t >= 0 && t <= 65536) r.param_t = t[bzs_pkg::POS_W-1:0];
         else r.out_of_range = 1'b1;
         return r;
      endfunction

      function void note_word(bzs_pkg::req_word_type w);
         want_q.push_back(solve_param(w));
      endfunction

      function void check_word(bzs_pkg::rsp_word_type got);
         bzs_pkg::rsp_word_type want;
         if (want_q.size() == 0) begin
            $error("unexpected result word param_t=%0d out_of_range=%0d",
                   got.param_t, got.out_of_range);
            errors++;
            return;
         end
         want = want_q.pop_front();
         if (got.param_t !== want.param_t) begin
            $error("param_t: expected %0d actual %0d", want.param_t, got.param_t);
            errors++;
         end
         if (got.out_of_range !== want.out_of_range) begin
            $error("out_of_range: expected %0d actual %0d",
                   want.out_of_range, got.out_of_range);
            errors++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   bzs_pkg::req_word_type req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   bzs_pkg::rsp_word_type rsp_data;

   int idle_pct = 0;        // sender idle chance per word
   int stall_pct = 0;       // receiver stall chance per cycle
   int cycle_count = 0;
   solver_scoreboard board = new();

   bezier_param_from_x_solver_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver back-pressure
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // Watch both handshakes; values read here are the ones from before the edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) board.note_word(req_data);
         if (rsp_valid && !rsp_stall) board.check_word(rsp_data);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > RUN_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Offer one word, with a random idle gap first; returns at the accepting edge
   task automatic send_word(bzs_pkg::req_word_type w);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.want_q.size() != 0) @(posedge clock);
   endtask

   function automatic bzs_pkg::req_word_type build_word(int lead, int p1v, int p2v, int span,
                                                        int pos);
      bzs_pkg::req_word_type w;
      w.point0 = lead;
      w.point1 = p1v;
      w.point2 = p2v;
      w.point3 = lead + span;
      w.position = pos[bzs_pkg::POS_W-1:0];
      return w;
   endfunction

   // Mostly ordinary monotone-ish curves, some raw noise and forced flat ends
   function automatic bzs_pkg::req_word_type random_word();
      bzs_pkg::req_word_type w;
      int kind, lead, span;
      kind = $urandom_range(0, 9);
      lead = $signed($urandom_range(0, 262143)) - 131072;
      span = $urandom_range(1, 262144);
      w = build_word(lead, lead + $urandom_range(0, span), lead + $urandom_range(0, span),
                     span, $urandom_range(0, 65536));
      case (kind)
         6, 7: begin
            w.point0 = $urandom();
            w.point1 = $urandom();
            w.point2 = $urandom();
            w.point3 = $urandom();
            w.position = bzs_pkg::POS_W'($urandom_range(0, 131071));
         end
         8: begin
            w.point1 = w.point0;
            if ($urandom_range(0, 1)) w.position = '0;
         end
         9: begin
            w.point2 = w.point3;
            if ($urandom_range(0, 1)) w.position = bzs_pkg::POS_ONE;
         end
         default: begin
            if ($urandom_range(0, 7) == 0) begin
               w.position = bzs_pkg::POS_W'($urandom_range(65537, 131071));
            end
         end
      endcase
      return w;
   endfunction

   task automatic run_phase(int sender_idle, int receiver_stall);
      idle_pct = sender_idle;
      stall_pct = receiver_stall;
      repeat (PHASE_WORDS) send_word(random_word());
      wait_drained();   // sender holds off until every result is back
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words: field extremes and the special cases
      send_word(build_word(0, 21845, 43690, 65536, 0));
      send_word(build_word(0, 21845, 43690, 65536, 65536));
      send_word(build_word(0, 21845, 43690, 65536, 32768));
      send_word(build_word(0, 0, 43690, 65536, 0));            // flat start
      send_word(build_word(0, 10000, 65536, 65536, 65536));    // flat end
      send_word(build_word(0, 0, 65536, 65536, 0));            // flat start, with p2 = p3 as well
      send_word(build_word(5, 5, 5, 0, 40000));                // zero slope
      send_word(build_word(0, 21845, 43690, 65536, 131071));   // position above one
      send_word(build_word(0, 0, 0, 65536, 1));
      send_word(build_word(-2147483648, 2147483647, -2147483648, -1, 65536));
      send_word(build_word(2147483647, -2147483648, 2147483647, 1, 12345));
      send_word(build_word(-2147483648, -2147483648, -2147483648, 0, 0));
      send_word(build_word(0, 200000, -200000, 65536, 30000)); // overshooting curve
      send_word(build_word(0, 65536, 0, 65536, 50000));
      send_word(build_word(-1, -1, -1, 1, 131071));
      send_word(build_word(65536, 0, 0, -65536, 20000));
      wait_drained();

      run_phase(23, 46);
      run_phase(46, 23);
      run_phase(0, 0);

      repeat (DRAIN_WAIT) @(posedge clock);
      if (board.errors == 0 && board.want_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
